// ===== rtl/core/atoi_base_stream_parser_macros.svh =====
// ----------------------------------------------------------------------------
// atoi_base_stream_parser_macros.svh
// Assertion macros for the base-alphabet integer parser.
// ----------------------------------------------------------------------------
`ifndef ATOI_BASE_STREAM_PARSER_MACROS_SVH
`define ATOI_BASE_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// check a condition in the same cycle as its trigger
`define ATOI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("atoi parser assertion failed");

// check a condition in the cycle after its trigger
`define ATOI_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("atoi parser assertion failed");

`else

`define ATOI_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ATOI_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/atoi_pkg.sv =====
// ----------------------------------------------------------------------------
// atoi_pkg
// Shared types, codes and character constants of the base-alphabet parser.
// ----------------------------------------------------------------------------
package atoi_pkg;

    // input word layout: mode in [1:0], symbol in [9:2], padded to 16 bits
    localparam int IN_TDATA_W = 16;
    localparam int MODE_W     = 2;
    localparam int SYM_W      = 8;

    // item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHAR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EMIT   = 2'd3;

    // character codes
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_TAB   = 8'd9;
    localparam logic [SYM_W-1:0] CH_CR    = 8'd13;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'd32;

    typedef enum logic [1:0] {
        PH_SKIP_WS,
        PH_SIGNS,
        PH_DIGITS,
        PH_DONE
    } parse_phase_t;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } fsm_state_t;

    // control broadcast to every cell of the alphabet row
    typedef struct packed {
        logic cmp_en;    // latch compare of the probe byte
        logic shift_en;  // shift the row by one cell
    } cell_ctl_t;

    function automatic logic is_space(input logic [SYM_W-1:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_sign(input logic [SYM_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

// ===== rtl/core/atoi_cell.sv =====
// ----------------------------------------------------------------------------
// atoi_cell
// One alphabet cell: holds a symbol, shifts it on to its neighbor and
// compares it with the probe byte.
// ----------------------------------------------------------------------------
module atoi_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                        aclk,
    input  atoi_pkg::cell_ctl_t         ctl,
    input  logic [atoi_pkg::SYM_W-1:0]  probe,
    input  logic [CNT_W-1:0]            count,
    input  logic [atoi_pkg::SYM_W-1:0]  sym_in,
    output logic [atoi_pkg::SYM_W-1:0]  sym_out,
    output logic                        hit
);
    import atoi_pkg::*;

    logic [SYM_W-1:0] sym_reg;
    logic             hit_reg;
    logic             occupied;

    // cell holds a loaded symbol only below the fill count
    assign occupied = CNT_W'(INDEX) < count;

    // advance the symbol row
    always_ff @(posedge aclk) begin
        if (ctl.shift_en) begin
            sym_reg <= sym_in;
        end
    end

    // hold the compare result for the next cycle
    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            hit_reg <= occupied && (sym_reg == probe);
        end
    end

    assign sym_out = sym_reg;
    assign hit     = hit_reg;

endmodule

// ===== rtl/core/atoi_out_buf.sv =====
// ----------------------------------------------------------------------------
// atoi_out_buf
// Two-entry result buffer: output register plus one skid entry.
// ----------------------------------------------------------------------------
module atoi_out_buf #(
    parameter int W = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [W-1:0] m_tdata
);
    import atoi_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_data_reg,  out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] skid_data_reg,  skid_data_next;
    logic         take;

    assign take = out_valid_reg && m_tready;

    // drain the output, refill from skid, then place a new word
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take) begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (push) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full     = skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/atoi_base_stream_parser.sv =====
// ----------------------------------------------------------------------------
// atoi_base_stream_parser
// Parses signed integers written in a loadable digit alphabet.
//
//  channel | direction | tdata fields (low bit up)        | tlast/tuser
//  s_      | in        | mode[1:0], symbol[9:2], pad      | none
//  m_      | out       | value[VALUE_BITS-1:0], base_ok   | none
//
//  Clear and end-of-string words stay idle; append and character words
//  go on to the calc state: the cell row compares the symbol in the accept
//  cycle, then the hit is encoded and the multiply-add by the base runs there.
//  Reset clears count, flags and parse state; the symbol row is not cleared.
//  s_tready drops in the calc state of a word, and while two results wait.
// ----------------------------------------------------------------------------
`include "atoi_base_stream_parser_macros.svh"

module atoi_base_stream_parser #(
    parameter int MAX_SYMBOLS = 64,
    parameter int VALUE_BITS  = 32,
    localparam int OUT_W      = ((VALUE_BITS + 1 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // mode [1:0], symbol [9:2], zero pad [15:10]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [atoi_pkg::IN_TDATA_W-1:0] s_tdata,
    // value [VALUE_BITS-1:0], base_ok [VALUE_BITS], zero pad above
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_W-1:0]                m_tdata
);
    import atoi_pkg::*;

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W = $clog2(MAX_SYMBOLS);

    fsm_state_t               state_reg, state_next;
    logic [MODE_W-1:0]        mode_reg;
    logic [SYM_W-1:0]         sym_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     invalid_reg, invalid_next;
    parse_phase_t             phase_reg, phase_next, phase_eff;
    logic                     neg_reg, neg_next;
    logic [VALUE_BITS-1:0]    acc_reg, acc_next;

    logic                     s_accept;
    logic [MODE_W-1:0]        in_mode;
    logic [SYM_W-1:0]         in_sym;
    cell_ctl_t                cell_ctl;
    logic                     store_full;
    logic                     buf_full;

    logic [SYM_W-1:0]         row_sym [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0]   hit_vec;
    logic                     any_hit;
    logic [IDX_W-1:0]         hit_pos;
    logic [IDX_W-1:0]         digit_idx;
    logic [VALUE_BITS-1:0]    acc_scaled;

    logic                     emit;
    logic                     base_ok;
    logic [VALUE_BITS-1:0]    emit_value;
    logic [OUT_W-1:0]         emit_data;

    assign in_mode    = s_tdata[MODE_W-1:0];
    assign in_sym     = s_tdata[MODE_W+SYM_W-1:MODE_W];
    assign s_accept   = s_tvalid && s_tready;
    assign store_full = count_reg == CNT_W'(MAX_SYMBOLS);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (in_mode == MODE_APPEND || in_mode == MODE_CHAR)) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready          = 1'b0;
        cell_ctl.cmp_en   = 1'b0;
        cell_ctl.shift_en = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready        = !buf_full;
                cell_ctl.cmp_en = s_tvalid && !buf_full;
            end
            ST_CALC: begin
                cell_ctl.shift_en = (mode_reg == MODE_APPEND) && !store_full;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // alphabet row: new symbols enter at cell 0 and move up
    for (genvar j = 0; j < MAX_SYMBOLS; j++) begin : g_cell
        atoi_cell #(
            .INDEX (j),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (cell_ctl),
            .probe   (in_sym),
            .count   (count_reg),
            .sym_in  ((j == 0) ? sym_reg : row_sym[(j == 0) ? 0 : j - 1]),
            .sym_out (row_sym[j]),
            .hit     (hit_vec[j])
        );
    end

    // encode the hit cell; cell j holds alphabet entry count-1-j
    always_comb begin
        hit_pos = '0;
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if (hit_vec[j]) begin
                hit_pos = hit_pos | IDX_W'(j);
            end
        end
    end

    assign any_hit    = |hit_vec;
    assign digit_idx  = IDX_W'(count_reg - CNT_W'(1) - CNT_W'(hit_pos));
    assign acc_scaled = VALUE_BITS'(acc_reg * VALUE_BITS'(count_reg));

    // phase that applies after skipping through finished stages
    always_comb begin
        phase_eff = phase_reg;
        if (phase_eff == PH_SKIP_WS) begin
            phase_eff = PH_SIGNS;
        end
        if (phase_eff == PH_SIGNS && !is_sign(sym_reg)) begin
            phase_eff = PH_DIGITS;
        end
    end

    // parser and alphabet update
    always_comb begin
        count_next   = count_reg;
        invalid_next = invalid_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        if (state_reg == ST_IDLE && s_accept) begin
            if (in_mode == MODE_CLEAR) begin
                count_next   = '0;
                invalid_next = 1'b0;
                phase_next   = PH_SKIP_WS;
                neg_next     = 1'b0;
                acc_next     = '0;
            end else if (in_mode == MODE_EMIT) begin
                phase_next = PH_SKIP_WS;
                neg_next   = 1'b0;
                acc_next   = '0;
            end
        end else if (state_reg == ST_CALC) begin
            if (mode_reg == MODE_APPEND) begin
                if (is_sign(sym_reg) || is_space(sym_reg) || any_hit || store_full) begin
                    invalid_next = 1'b1;
                end
                if (!store_full) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end else if (!(phase_reg == PH_SKIP_WS && is_space(sym_reg))) begin
                phase_next = phase_eff;
                if (phase_eff == PH_SIGNS && sym_reg == CH_MINUS) begin
                    neg_next = !neg_reg;
                end
                if (phase_eff == PH_DIGITS) begin
                    if (any_hit) begin
                        acc_next = acc_scaled + VALUE_BITS'(digit_idx);
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            invalid_reg <= 1'b0;
            phase_reg   <= PH_SKIP_WS;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            invalid_reg <= invalid_next;
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            acc_reg     <= acc_next;
        end
    end

    // hold the accepted word for the calc state
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= in_mode;
            sym_reg  <= in_sym;
        end
    end

    // build the result word on end of string
    assign emit       = s_accept && (in_mode == MODE_EMIT);
    assign base_ok    = !invalid_reg && (count_reg >= CNT_W'(2));
    assign emit_value = !base_ok ? '0 : (neg_reg ? (VALUE_BITS'(0) - acc_reg) : acc_reg);
    assign emit_data  = OUT_W'({base_ok, emit_value});

    atoi_out_buf #(
        .W (OUT_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (emit_data),
        .full      (buf_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // checks
    `ATOI_ASSERT_IMP(a_calc_blocks_input, aclk, aresetn, state_reg == ST_CALC, !s_tready)
    `ATOI_ASSERT_IMP(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_SYMBOLS))
    `ATOI_ASSERT_NXT(a_clear_resets, aclk, aresetn, s_accept && in_mode == MODE_CLEAR, count_reg == '0 && !invalid_reg && acc_reg == '0)
    `ATOI_ASSERT_NXT(a_calc_one_cycle, aclk, aresetn, state_reg == ST_CALC, state_reg == ST_IDLE)
    `ATOI_ASSERT_IMP(a_skid_needs_out, aclk, aresetn, buf_full, m_tvalid)

endmodule

// ===== tb/tb_atoi_base_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tb_atoi_base_stream_parser
// Self-checking bench for the loadable-alphabet integer parser. A queue of
// words feeds a clocked stream driver; every accepted word runs through a
// behavioral parser kept here, and each emitted value is compared with the
// oldest predicted one. Sender gaps and receiver stalls vary by phase, with
// one long receiver hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_atoi_base_stream_parser;
    import atoi_pkg::*;

    localparam int ALPHA_DEPTH = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_WORDS = 80;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  sym;
    } stim_word_t;

    typedef struct {
        logic [31:0] value;
        logic        ok;
    } parse_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // pending words, predicted results
    stim_word_t    word_queue[$];
    parse_result_t expected_results[$];
    stim_word_t    next_word;

    // parser state as predicted from accepted words
    logic [SYM_W-1:0] abc_store[ALPHA_DEPTH];
    int               abc_count = 0;
    logic             abc_bad   = 1'b0;
    parse_phase_t     ph        = PH_SKIP_WS;
    logic             neg       = 1'b0;
    logic [31:0]      acc       = '0;

    // generator's view of the alphabet, used to pick digits
    logic [SYM_W-1:0] gen_syms[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int mismatches   = 0;
    int words_in     = 0;
    int results_seen = 0;
    int invalid_seen = 0;
    int neg_seen     = 0;

    atoi_base_stream_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // mode [1:0], symbol [9:2], pad [15:10]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // value [31:0], base_ok [32], pad [39:33]
    );

    // 12-unit clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic is_blank(input logic [SYM_W-1:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == CH_SPACE;
    endfunction

    function automatic logic is_sign_char(input logic [SYM_W-1:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic int digit_index(input logic [SYM_W-1:0] c);
        for (int k = 0; k < abc_count; k++) begin
            if (abc_store[k] == c) begin
                return k;
            end
        end
        return -1;
    endfunction

    // advance the predicted parser by one accepted word
    task automatic parse_word(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] c);
        int            pos;
        parse_result_t r;
        case (mode)
            MODE_CLEAR: begin
                abc_count = 0;
                abc_bad   = 1'b0;
                ph        = PH_SKIP_WS;
                neg       = 1'b0;
                acc       = '0;
            end
            MODE_APPEND: begin
                if (is_blank(c) || is_sign_char(c) || digit_index(c) >= 0) begin
                    abc_bad = 1'b1;
                end
                // drop the symbol once the store is full
                if (abc_count >= ALPHA_DEPTH) begin
                    abc_bad = 1'b1;
                end else begin
                    abc_store[abc_count] = c;
                    abc_count++;
                end
            end
            MODE_CHAR: begin
                if (ph == PH_SKIP_WS && !is_blank(c)) begin
                    ph = PH_SIGNS;
                end
                if (ph == PH_SIGNS) begin
                    if (is_sign_char(c)) begin
                        if (c == CH_MINUS) begin
                            neg = !neg;
                        end
                    end else begin
                        ph = PH_DIGITS;
                    end
                end
                if (ph == PH_DIGITS) begin
                    pos = digit_index(c);
                    if (pos >= 0) begin
                        acc = acc * 32'(abc_count) + 32'(pos);
                    end else begin
                        ph = PH_DONE;
                    end
                end
            end
            MODE_EMIT: begin
                r.ok    = !abc_bad && abc_count >= 2;
                r.value = r.ok ? (neg ? 32'd0 - acc : acc) : 32'd0;
                expected_results.push_back(r);
                ph  = PH_SKIP_WS;
                neg = 1'b0;
                acc = '0;
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("MISMATCH %s: expected %08h, got %08h", what, want, got);
        mismatches++;
    endtask

    // stream driver: hold a word until taken, then load the next or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_word(s_tdata[1:0], s_tdata[9:2]);
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (word_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_word = word_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, next_word.sym, next_word.mode};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each taken word with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected result", '0, m_tdata[31:0]);
                end else begin
                    if (m_tdata[31:0] !== expected_results[0].value) begin
                        flag_mismatch("value", expected_results[0].value, m_tdata[31:0]);
                    end
                    if (m_tdata[32] !== expected_results[0].ok) begin
                        flag_mismatch("base_ok", 32'(expected_results[0].ok),
                                      32'(m_tdata[32]));
                    end
                    if (!expected_results[0].ok) begin
                        invalid_seen++;
                    end else if (expected_results[0].value[31]) begin
                        neg_seen++;
                    end
                    void'(expected_results.pop_front());
                end
                results_seen++;
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // count down a long receiver hold
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic push_word(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym);
        stim_word_t w;
        w.mode = mode;
        w.sym  = sym;
        word_queue.push_back(w);
    endtask

    function automatic logic gen_has(input logic [SYM_W-1:0] c);
        foreach (gen_syms[i]) begin
            if (gen_syms[i] == c) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [SYM_W-1:0] pick_blank();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CH_SPACE : SYM_W'(r);
    endfunction

    function automatic logic [SYM_W-1:0] fresh_symbol();
        logic [SYM_W-1:0] c;
        do begin
            c = SYM_W'($urandom_range(0, 255));
        end while (is_blank(c) || is_sign_char(c) || gen_has(c));
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] bad_symbol();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return pick_blank();
            default: return (gen_syms.size() > 0) ?
                gen_syms[$urandom_range(0, gen_syms.size() - 1)] : CH_SPACE;
        endcase
    endfunction

    // clear and load an alphabet of n symbols, each bad with a chance of bad_pct percent
    task automatic build_alphabet(input int n, input int bad_pct);
        logic [SYM_W-1:0] c;
        push_word(MODE_CLEAR, SYM_W'($urandom_range(0, 255)));
        gen_syms.delete();
        for (int i = 0; i < n; i++) begin
            c = ($urandom_range(99) < bad_pct) ? bad_symbol() : fresh_symbol();
            push_word(MODE_APPEND, c);
            gen_syms.push_back(c);
        end
    endtask

    function automatic int random_alphabet_size();
        int r;
        r = $urandom_range(99);
        if (r < 6) begin
            return $urandom_range(0, 1);
        end else if (r < 12) begin
            return $urandom_range(60, 68);
        end
        return $urandom_range(2, 16);
    endfunction

    // one string: blanks, signs, digits, optional tail, then end of string; now and then raw noise instead
    task automatic build_string();
        int ndig;
        if ($urandom_range(99) < 8) begin
            // raw noise
            repeat ($urandom_range(1, 6)) begin
                push_word(MODE_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
            end
            return;
        end
        repeat ($urandom_range(0, 3)) push_word(MODE_CHAR, pick_blank());
        repeat ($urandom_range(0, 3)) begin
            push_word(MODE_CHAR, $urandom_range(1) ? CH_MINUS : CH_PLUS);
        end
        ndig = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(9, 20);
        for (int i = 0; i < ndig; i++) begin
            if (gen_syms.size() > 0 && $urandom_range(99) < 95) begin
                push_word(MODE_CHAR, gen_syms[$urandom_range(0, gen_syms.size() - 1)]);
            end else begin
                push_word(MODE_CHAR, SYM_W'($urandom_range(0, 255)));
            end
            // grow the alphabet in the middle of a string now and then
            if ($urandom_range(99) < 3) begin
                gen_syms.push_back(fresh_symbol());
                push_word(MODE_APPEND, gen_syms[$]);
            end
        end
        if ($urandom_range(1)) begin
            repeat ($urandom_range(1, 4)) push_word(MODE_CHAR, SYM_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(99) < 5) begin
            push_word(MODE_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
        end
        push_word(MODE_EMIT, SYM_W'($urandom_range(0, 255)));
    endtask

    // hold until every word is taken and every result has come back
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (word_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    int mix_tx[4] = '{0, 79, 0, 22};
    int mix_rx[4] = '{0, 0, 79, 22};

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty alphabet at end of string
        push_word(MODE_EMIT, 8'hFF);
        // four-symbol alphabet with a zero byte and both byte extremes
        push_word(MODE_CLEAR, 8'h00);
        push_word(MODE_APPEND, 8'h00);
        push_word(MODE_APPEND, 8'hFF);
        push_word(MODE_APPEND, 8'h01);
        push_word(MODE_APPEND, 8'h80);
        // blanks, a run of signs, digits, an alphabet change mid-string, a tail
        push_word(MODE_CHAR, CH_TAB);
        push_word(MODE_CHAR, CH_CR);
        push_word(MODE_CHAR, CH_SPACE);
        push_word(MODE_CHAR, CH_PLUS);
        push_word(MODE_CHAR, CH_MINUS);
        push_word(MODE_CHAR, CH_MINUS);
        push_word(MODE_CHAR, CH_MINUS);
        push_word(MODE_CHAR, 8'hFF);
        push_word(MODE_CHAR, 8'h00);
        push_word(MODE_APPEND, 8'h7F);
        push_word(MODE_CHAR, 8'h7F);
        push_word(MODE_CHAR, 8'h41);
        push_word(MODE_CHAR, 8'h01);
        push_word(MODE_EMIT, 8'h00);
        // sign symbol spoils the alphabet
        push_word(MODE_APPEND, CH_MINUS);
        push_word(MODE_EMIT, 8'hAA);
        wait_drained();

        // long receiver hold with the sender pushing; second alphabet overflows
        hold_left = HOLD_CYCLES;
        build_alphabet(10, 0);
        repeat (6) build_string();
        build_alphabet(ALPHA_DEPTH + 2, 0);
        repeat (4) build_string();
        wait_drained();

        // random traffic under each idle and stall mix
        for (int m = 0; m < 4; m++) begin
            tx_idle_pct  = mix_tx[m];
            rx_stall_pct = mix_rx[m];
            build_alphabet(random_alphabet_size(), 4);
            while (word_queue.size() < PHASE_WORDS) begin
                if ($urandom_range(99) < 20) begin
                    build_alphabet(random_alphabet_size(), 4);
                end
                build_string();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Checked %0d results from %0d words: %0d with a bad alphabet, %0d negative.",
                 results_seen, words_in, invalid_seen, neg_seen);
        $display("Ran four idle/stall mixes, a %0d-cycle receiver hold and a store overflow.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/atoi_pkg.sv
rtl/core/atoi_cell.sv
rtl/core/atoi_out_buf.sv
rtl/core/atoi_base_stream_parser.sv
tb/tb_atoi_base_stream_parser.sv
